>>> design/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types and constants for the nearest cell center search unit.
// ----------------------------------------------------------------------------
package ncs_pkg;

    localparam int MAX_CELLS = 4096;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int COORD_W   = 24;
    localparam int SLOT_W    = 12;
    localparam int DIST_W    = 49;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ENTRY_W   = 2 * COORD_W;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  nearest_slot;
        logic [DIST_W-1:0]  nearest_dist_sq;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;       // capture the input item
        logic exec;        // carry out clear or append
        logic scan_start;  // rewind scan address
        logic scan_issue;  // read one entry and advance
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       cnt_zero;
        logic       scan_last;
        logic       pipe_busy;
        logic       out_free;
    } t_dp_sts;

endpackage

>>> design/ncs_ctrl.sv
// ----------------------------------------------------------------------------
// ncs_ctrl
// Sequencer: accepts one item, runs clear, append or a table scan, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ncs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ncs_pkg::t_dp_sts i_sts,
    output ncs_pkg::t_dp_cmd o_cmd
);

    ncs_pkg::t_state r_state;
    ncs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ncs_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ncs_pkg::S_EXEC;
                end
            end
            ncs_pkg::S_EXEC: begin
                if (i_sts.req == ncs_pkg::REQ_QUERY) begin
                    if (i_sts.cnt_zero) begin
                        n_state = ncs_pkg::S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ncs_pkg::S_SCAN;
                    end
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = ncs_pkg::S_DONE;
                end
            end
            ncs_pkg::S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ncs_pkg::S_DRAIN;
                end
            end
            ncs_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ncs_pkg::S_DONE;
                end
            end
            ncs_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ncs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ncs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ncs_dpath.sv
// ----------------------------------------------------------------------------
// ncs_dpath
// Center table, entry count, distance pipeline, best tracking and the
// output register.
// ----------------------------------------------------------------------------
module ncs_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ncs_pkg::t_dp_cmd  i_cmd,
    output ncs_pkg::t_dp_sts  o_sts,
    input  ncs_pkg::t_in_item i_in_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output ncs_pkg::t_out_item o_out_data
);

    // table: x in the low half, y in the high half
    logic [ncs_pkg::ENTRY_W-1:0] mem [ncs_pkg::MAX_CELLS];

    logic [1:0]                         r_req;
    logic signed [ncs_pkg::COORD_W-1:0] r_qx;
    logic signed [ncs_pkg::COORD_W-1:0] r_qy;
    logic [ncs_pkg::CNT_W-1:0]          r_count;
    logic [ncs_pkg::ADDR_W-1:0]         r_addr;
    logic [1:0]                         r_res_status;
    logic [ncs_pkg::ADDR_W-1:0]         r_res_slot;

    // pipeline: read, difference, square, compare
    logic                               r_v1, r_v2, r_v3;
    logic [ncs_pkg::ADDR_W-1:0]         r_slot1, r_slot2, r_slot3;
    logic [ncs_pkg::ENTRY_W-1:0]        r_rd_data;
    logic signed [ncs_pkg::DIFF_W-1:0]  r_dx, r_dy;
    logic [ncs_pkg::DIST_W-1:0]         r_sqx, r_sqy;

    logic                               r_found;
    logic [ncs_pkg::DIST_W-1:0]         r_best;
    logic [ncs_pkg::ADDR_W-1:0]         r_best_slot;

    logic                               r_out_valid;
    ncs_pkg::t_out_item                 r_out_data;
    ncs_pkg::t_out_item                 n_out_data;

    logic signed [ncs_pkg::COORD_W-1:0] w_cx, w_cy;
    logic signed [2*ncs_pkg::DIFF_W-1:0] w_sqx, w_sqy;
    logic [ncs_pkg::DIST_W-1:0]         w_sum;
    logic                               w_full;

    assign w_full = (r_count == ncs_pkg::CNT_W'(ncs_pkg::MAX_CELLS));
    assign w_cx   = r_rd_data[ncs_pkg::COORD_W-1:0];
    assign w_cy   = r_rd_data[ncs_pkg::ENTRY_W-1:ncs_pkg::COORD_W];
    assign w_sqx  = r_dx * r_dx;
    assign w_sqy  = r_dy * r_dy;
    assign w_sum  = r_sqx + r_sqy;

    assign o_sts.req       = r_req;
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.scan_last = ({1'b0, r_addr} == r_count - ncs_pkg::CNT_W'(1));
    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // item capture, clear and append
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req        <= i_in_data.req_type;
            r_qx         <= i_in_data.pos_x;
            r_qy         <= i_in_data.pos_y;
            r_res_status <= ncs_pkg::ST_OK;
            r_res_slot   <= '0;
        end
        if (i_cmd.exec && r_req == ncs_pkg::REQ_APPEND) begin
            if (w_full) begin
                r_res_status <= ncs_pkg::ST_FULL;
            end else begin
                r_res_slot <= r_count[ncs_pkg::ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (r_req == ncs_pkg::REQ_CLEAR) begin
                r_count <= '0;
            end else if (r_req == ncs_pkg::REQ_APPEND && !w_full) begin
                r_count <= r_count + ncs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_req == ncs_pkg::REQ_APPEND && !w_full) begin
            mem[r_count[ncs_pkg::ADDR_W-1:0]] <= {r_qy, r_qx};
        end
        if (i_cmd.scan_issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // scan address and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.scan_issue) begin
                r_addr <= r_addr + ncs_pkg::ADDR_W'(1);
            end
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.latch) begin
                r_found <= 1'b0;
            end else if (r_v3) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot1 <= r_addr;
        r_slot2 <= r_slot1;
        r_slot3 <= r_slot2;
        r_dx    <= ncs_pkg::DIFF_W'(w_cx) - ncs_pkg::DIFF_W'(r_qx);
        r_dy    <= ncs_pkg::DIFF_W'(w_cy) - ncs_pkg::DIFF_W'(r_qy);
        r_sqx   <= w_sqx[ncs_pkg::DIST_W-1:0];
        r_sqy   <= w_sqy[ncs_pkg::DIST_W-1:0];
        // keep the first strict minimum: a tie leaves the earlier slot
        if (r_v3 && (!r_found || w_sum < r_best)) begin
            r_best      <= w_sum;
            r_best_slot <= r_slot3;
        end
    end

    // result assembly
    always_comb begin
        n_out_data = '0;
        if (r_req == ncs_pkg::REQ_QUERY) begin
            if (r_found) begin
                n_out_data.nearest_slot    = ncs_pkg::SLOT_W'(r_best_slot);
                n_out_data.nearest_dist_sq = r_best;
            end else begin
                n_out_data.status = ncs_pkg::ST_EMPTY;
            end
        end else begin
            n_out_data.status       = r_res_status;
            n_out_data.nearest_slot = ncs_pkg::SLOT_W'(r_res_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ncs_pkg::CNT_W'(ncs_pkg::MAX_CELLS))
        else $error("entry count beyond table size");

    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_v1 || r_v2 || r_v3))
        else $error("result loaded while distances still in flight");

    a_found_after_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_cmd.latch |=> r_found)
        else $error("compare stage did not mark a candidate");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

>>> design/nearest_cell_center_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_cell_center_search_unit
// Table of 2D cell centers with brute-force nearest-center queries.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A clear, an append or a query on an empty
// table passes through the execute state to the output register; any other
// query scans the stored centers through the single read port of the center
// table, one entry per cycle, through a four-stage distance pipeline, and
// drains the pipeline before its result is loaded. A result waits in an output
// register, so the next item is accepted while the previous result is still
// stalled. Centers must be appended in ascending cell-id order so slots match
// cell ids; the table is not cleared at reset, only its entry count.
module nearest_cell_center_search_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ncs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ncs_pkg::t_out_item o_out_data
);

    ncs_pkg::t_dp_cmd w_cmd;
    ncs_pkg::t_dp_sts w_sts;

    ncs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ncs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/nearest_center_checker.sv
// ----------------------------------------------------------------------------
// nearest_center_checker
// Watches both channels of the nearest cell center search unit. It keeps its
// own copy of the center table, works out the result of every accepted
// request, and compares the results that leave the unit, in order.
// ----------------------------------------------------------------------------
module nearest_center_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  ncs_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  ncs_pkg::t_out_item i_out_data,
    output int                 o_mismatches,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [ncs_pkg::COORD_W-1:0] centre_x [ncs_pkg::MAX_CELLS];
    logic signed [ncs_pkg::COORD_W-1:0] centre_y [ncs_pkg::MAX_CELLS];
    int                                 stored_centres = 0;

    ncs_pkg::t_out_item                 awaited_results [$];
    ncs_pkg::t_out_item                 want;
    ncs_pkg::t_out_item                 got;
    int                                 mismatches = 0;
    int                                 pending_cnt = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending_cnt;

    // Apply one request to the local table and return the result it causes.
    function automatic ncs_pkg::t_out_item nearest_centre_result(ncs_pkg::t_in_item req);
        ncs_pkg::t_out_item         r;
        logic [ncs_pkg::DIST_W-1:0] best;
        logic [ncs_pkg::DIST_W-1:0] d;
        longint                     dx;
        longint                     dy;
        logic                       found;
        r     = '0;
        best  = '0;
        found = 1'b0;
        case (req.req_type)
            ncs_pkg::REQ_CLEAR: begin
                stored_centres = 0;
            end
            ncs_pkg::REQ_APPEND: begin
                if (stored_centres >= ncs_pkg::MAX_CELLS) begin
                    r.status = ncs_pkg::ST_FULL;
                end else begin
                    centre_x[ncs_pkg::ADDR_W'(stored_centres)] = req.pos_x;
                    centre_y[ncs_pkg::ADDR_W'(stored_centres)] = req.pos_y;
                    r.nearest_slot = ncs_pkg::SLOT_W'(stored_centres);
                    stored_centres++;
                end
            end
            ncs_pkg::REQ_QUERY: begin
                for (int i = 0; i < stored_centres; i++) begin
                    dx = longint'($signed(centre_x[ncs_pkg::ADDR_W'(i)]))
                       - longint'($signed(req.pos_x));
                    dy = longint'($signed(centre_y[ncs_pkg::ADDR_W'(i)]))
                       - longint'($signed(req.pos_y));
                    d  = ncs_pkg::DIST_W'(dx * dx + dy * dy);
                    // strict compare: the lower slot wins a tie
                    if (!found || d < best) begin
                        found          = 1'b1;
                        best           = d;
                        r.nearest_slot = ncs_pkg::SLOT_W'(i);
                    end
                end
                if (found)
                    r.nearest_dist_sq = best;
                else
                    r.status = ncs_pkg::ST_EMPTY;
            end
            default: begin
                // unused code: no state change, all-zero result
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_centres = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result item: status %0d slot %0d dist %0d",
                           got.status, got.nearest_slot, got.nearest_dist_sq);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.nearest_slot !== want.nearest_slot) begin
                        $error("nearest_slot: expected %0d, actual %0d",
                               want.nearest_slot, got.nearest_slot);
                        mismatches++;
                    end
                    if (got.nearest_dist_sq !== want.nearest_dist_sq) begin
                        $error("nearest_dist_sq: expected %0d, actual %0d",
                               want.nearest_dist_sq, got.nearest_dist_sq);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(nearest_centre_result(i_in_data));
        end
        pending_cnt = awaited_results.size();
    end

endmodule

>>> tb/nearest_cell_center_search_unit_tb.sv
// ----------------------------------------------------------------------------
// nearest_cell_center_search_unit_tb
// Drives clear, append and query requests into the search unit: a directed
// pass over the coordinate extremes, ties and empty and full tables, a full
// table fill, then random append/query sequences with noise. Both sides
// idle at random; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module nearest_cell_center_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 10;
    localparam int IDLE_PCT       = 14;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 140;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int CW             = ncs_pkg::COORD_W;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    ncs_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ncs_pkg::t_out_item out_data;

    int        mismatches;
    int        pending;
    logic      calm        = 1'b0;
    int        holds_asked = 0;
    int        items_sent  = 0;
    int        quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    nearest_cell_center_search_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    nearest_center_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus long hold-offs on request.
    initial begin : result_side
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Offer one item, hold it until accepted, then drop valid.
    task automatic issue(input logic [1:0] req, input logic signed [CW-1:0] x,
                         input logic signed [CW-1:0] y);
        ncs_pkg::t_in_item it;
        it.req_type = req;
        it.pos_x    = x;
        it.pos_y    = y;
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(5))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3:    return CW'($urandom);
            default: return CW'(int'($urandom_range(4095)) - 2048);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] near_coord();
        return CW'(int'($urandom_range(4095)) - 2048);
    endfunction

    initial begin : stimulus
        int                 seq;
        int                 goal;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, ties, unused code
        issue(ncs_pkg::REQ_QUERY, CW'(0), CW'(0));
        issue(REQ_UNUSED, COORD_MAX, COORD_MIN);
        issue(ncs_pkg::REQ_APPEND, COORD_MAX, COORD_MAX);
        issue(ncs_pkg::REQ_QUERY, COORD_MIN, COORD_MIN);
        issue(ncs_pkg::REQ_APPEND, COORD_MIN, COORD_MIN);
        issue(ncs_pkg::REQ_APPEND, COORD_MIN, COORD_MAX);
        issue(ncs_pkg::REQ_APPEND, COORD_MAX, COORD_MIN);
        issue(ncs_pkg::REQ_QUERY, COORD_MIN, COORD_MIN);
        issue(ncs_pkg::REQ_QUERY, CW'(0), CW'(0));
        issue(ncs_pkg::REQ_APPEND, COORD_MAX, COORD_MAX);
        issue(ncs_pkg::REQ_QUERY, COORD_MAX, COORD_MAX);
        issue(ncs_pkg::REQ_APPEND, CW'(0), CW'(0));
        issue(ncs_pkg::REQ_APPEND, CW'(2), CW'(0));
        issue(ncs_pkg::REQ_QUERY, CW'(1), CW'(0));
        issue(ncs_pkg::REQ_QUERY, CW'(-1), CW'(-1));
        issue(ncs_pkg::REQ_CLEAR, COORD_MAX, COORD_MIN);
        issue(ncs_pkg::REQ_QUERY, CW'(5), CW'(5));
        issue(REQ_UNUSED, CW'(0), CW'(0));
        issue(ncs_pkg::REQ_APPEND, CW'(-1), CW'(1));
        issue(ncs_pkg::REQ_QUERY, COORD_MAX, COORD_MIN);
        issue(ncs_pkg::REQ_CLEAR, CW'(0), CW'(0));

        // fill the table to the last slot, then overflow it
        calm = 1'b1;
        for (int i = 0; i < ncs_pkg::MAX_CELLS - 1; i++)
            issue(ncs_pkg::REQ_APPEND, pick_coord(), pick_coord());
        issue(ncs_pkg::REQ_APPEND, COORD_MAX - CW'(5), CW'(77));
        calm = 1'b0;
        issue(ncs_pkg::REQ_QUERY, COORD_MAX - CW'(5), CW'(77));
        issue(ncs_pkg::REQ_APPEND, CW'(0), CW'(0));
        issue(REQ_UNUSED, CW'(1), CW'(1));
        issue(ncs_pkg::REQ_QUERY, pick_coord(), pick_coord());
        issue(ncs_pkg::REQ_APPEND, COORD_MIN, COORD_MAX);
        issue(ncs_pkg::REQ_CLEAR, CW'(0), CW'(0));
        issue(ncs_pkg::REQ_QUERY, COORD_MIN, CW'(0));

        // random: mostly clear/append/query sequences, some noise
        goal = items_sent + RANDOM_ITEMS;
        seq  = 0;
        while (items_sent < goal) begin
            seq++;
            if (seq == 4)
                holds_asked++;
            if (seq == 10)
                wait (pending == 0);
            calm = (seq >= 12 && seq < 20);
            if ($urandom_range(9) < 8) begin
                issue(ncs_pkg::REQ_CLEAR, pick_coord(), pick_coord());
                repeat ($urandom_range(1, 10))
                    issue(ncs_pkg::REQ_APPEND, pick_coord(), pick_coord());
                if ($urandom_range(2) == 0) begin
                    // two centers equally far from the midpoint query
                    bx = near_coord();
                    by = near_coord();
                    issue(ncs_pkg::REQ_APPEND, bx, by);
                    issue(ncs_pkg::REQ_APPEND, bx + CW'(2), by);
                    issue(ncs_pkg::REQ_QUERY, bx + CW'(1), by);
                end
                repeat ($urandom_range(1, 4))
                    issue(ncs_pkg::REQ_QUERY, pick_coord(), pick_coord());
            end else begin
                repeat ($urandom_range(1, 4))
                    issue(2'($urandom_range(3)), pick_coord(), pick_coord());
            end
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
design/ncs_pkg.sv
design/ncs_ctrl.sv
design/ncs_dpath.sv
design/nearest_cell_center_search_unit.sv
tb/nearest_center_checker.sv
tb/nearest_cell_center_search_unit_tb.sv
